[hw/rtl/multichannel_frame_ring_fifo_macros.svh]
// ----------------------------------------------------------------------------
// Frame ring FIFO assertion macros
// Concurrent checks clocked on clk and disabled during rst.
// ----------------------------------------------------------------------------
`ifndef MULTICHANNEL_FRAME_RING_FIFO_MACROS_SVH
`define MULTICHANNEL_FRAME_RING_FIFO_MACROS_SVH

// Same-cycle implication.
`define MFRF_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define MFRF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/mfrf_pkg.sv]
// ----------------------------------------------------------------------------
// mfrf_pkg
// Shared codes and controller/datapath interface types of the frame FIFO.
// ----------------------------------------------------------------------------
package mfrf_pkg;

  // Request codes; any other code is a status query.
  localparam logic [1:0] FUNC_WRITE = 2'd0;
  localparam logic [1:0] FUNC_READ  = 2'd1;

  // Result kinds.
  localparam logic [1:0] KIND_WRITE_ACK   = 2'd0;
  localparam logic [1:0] KIND_READ_SAMPLE = 2'd1;
  localparam logic [1:0] KIND_READ_EMPTY  = 2'd2;
  localparam logic [1:0] KIND_STATUS      = 2'd3;

  // Commands from the controller.
  typedef struct packed {
    logic wr_item;      // write sample beat taken
    logic rd_start;     // read request with frames to return
    logic rd_empty;     // read request with nothing to return
    logic stat_item;    // status query taken
    logic mem_rd;       // fetch next read sample from the store
    logic load_sample;  // move fetched sample into the output register
  } mfrf_cmd_t;

  // Status to the controller.
  typedef struct packed {
    logic out_free;     // output register can take a beat this cycle
    logic rd_zero;      // current read request returns no frame
    logic rd_last;      // fetched sample is the final one of the read
  } mfrf_stat_t;

endpackage

[hw/rtl/mfrf_ctrl.sv]
// ----------------------------------------------------------------------------
// mfrf_ctrl
// Sequencer: takes request beats and steps reads one sample at a time.
// ----------------------------------------------------------------------------
module mfrf_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [1:0]             func,
  input  mfrf_pkg::mfrf_stat_t   stat,
  output mfrf_pkg::mfrf_cmd_t    cmd
);
  import mfrf_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE    = 3'b001,
    ST_RD_ADDR = 3'b010,
    ST_RD_DATA = 3'b100
  } state_t;

  state_t state;
  state_t state_next;
  logic   take;

  assign in_ready = !rst && (state == ST_IDLE) && stat.out_free;
  assign take     = in_valid && in_ready;

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (take) begin
          case (func)
            FUNC_WRITE: begin
              cmd.wr_item = 1'b1;
            end
            FUNC_READ: begin
              if (stat.rd_zero) begin
                cmd.rd_empty = 1'b1;
              end else begin
                cmd.rd_start = 1'b1;
                state_next   = ST_RD_ADDR;
              end
            end
            default: begin
              cmd.stat_item = 1'b1;
            end
          endcase
        end
      end
      ST_RD_ADDR: begin
        cmd.mem_rd = 1'b1;
        state_next = ST_RD_DATA;
      end
      ST_RD_DATA: begin
        if (stat.out_free) begin
          cmd.load_sample = 1'b1;
          state_next      = stat.rd_last ? ST_IDLE : ST_RD_ADDR;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

[hw/rtl/mfrf_datapath.sv]
// ----------------------------------------------------------------------------
// mfrf_datapath
// Sample store, ring pointers, burst tracking, read counters, output register.
// ----------------------------------------------------------------------------
module mfrf_datapath #(
  parameter int CAPACITY_FRAMES = 1024,
  parameter int MAX_CHANNELS    = 8,
  parameter int MAX_READ_FRAMES = 8
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [3:0]             cfg_data,
  input  logic [31:0]            sample,
  input  logic                   burst_start,
  input  logic [10:0]            burst_frames,
  input  logic [3:0]             max_frames,
  input  mfrf_pkg::mfrf_cmd_t    cmd,
  output mfrf_pkg::mfrf_stat_t   stat,
  input  logic                   out_ready,
  output logic                   out_valid,
  output logic [1:0]             kind,
  output logic [31:0]            sample_res,
  output logic                   accepted,
  output logic [3:0]             frames_returned,
  output logic [10:0]            frames_pending,
  output logic [31:0]            overflow_count,
  output logic                   last
);
  import mfrf_pkg::*;

  localparam int SW    = $clog2(CAPACITY_FRAMES);
  localparam int PW    = SW + 1;
  localparam int CW    = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int NCW   = $clog2(MAX_CHANNELS + 1);
  localparam int RFW   = $clog2(MAX_READ_FRAMES + 1);
  localparam int RW    = 11 + NCW;
  localparam int DEPTH = CAPACITY_FRAMES * MAX_CHANNELS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [31:0]    mem [DEPTH];
  logic [31:0]    mem_q;

  logic [3:0]     num_ch;
  logic [PW-1:0]  wp, wp_next;
  logic [PW-1:0]  rp, rp_next;
  logic           bacc, bacc_next;
  logic [RW-1:0]  rem, rem_next;
  logic [PW-1:0]  wfr, wfr_next;
  logic [CW-1:0]  wch, wch_next;
  logic [NCW-1:0] burst_ch, burst_ch_next;
  logic [31:0]    ovf, ovf_next;

  logic [PW-1:0]  rd_frame;
  logic [CW-1:0]  rd_ch;
  logic [RFW-1:0] rd_fdone;
  logic [RFW-1:0] rd_n;
  logic [NCW-1:0] rd_nch;

  logic [NCW-1:0] eff_ch;
  logic [PW-1:0]  pend, pend_after;
  logic [PW-1:0]  free_frames;
  logic [31:0]    rd_sat, rd_cnt, pend_wide;
  logic [RW-1:0]  burst_len;
  logic           wr_en, acc;
  logic [NCW-1:0] ch_use;
  logic [PW-1:0]  wfr_use;
  logic [CW-1:0]  wch_use;
  logic [AW-1:0]  waddr, raddr;

  // Effective channel count: zero acts as one, clamp at the maximum.
  always_comb begin
    if (num_ch == 4'd0) begin
      eff_ch = NCW'(1);
    end else if (32'(num_ch) > MAX_CHANNELS) begin
      eff_ch = NCW'(MAX_CHANNELS);
    end else begin
      eff_ch = NCW'(num_ch);
    end
  end

  assign pend        = PW'(wp - rp);
  assign free_frames = PW'(CAPACITY_FRAMES) - pend;
  assign burst_len   = RW'(burst_frames) * RW'(eff_ch) - RW'(1);

  // Frames a read request returns.
  always_comb begin
    rd_sat = (32'(max_frames) > MAX_READ_FRAMES) ? 32'(MAX_READ_FRAMES) : 32'(max_frames);
    rd_cnt = (rd_sat > 32'(pend)) ? 32'(pend) : rd_sat;
  end

  assign stat.rd_zero  = (rd_cnt == 32'd0);
  assign stat.out_free = !out_valid || out_ready;
  assign stat.rd_last  = (32'(rd_ch) + 32'd1 == 32'(rd_nch)) &&
                         (32'(rd_fdone) + 32'd1 == 32'(rd_n));

  // Write burst bookkeeping.
  always_comb begin
    wp_next       = wp;
    bacc_next     = bacc;
    rem_next      = rem;
    wfr_next      = wfr;
    wch_next      = wch;
    burst_ch_next = burst_ch;
    ovf_next      = ovf;
    wr_en         = 1'b0;
    acc           = 1'b0;
    ch_use        = burst_ch;
    wfr_use       = wfr;
    wch_use       = wch;
    if (cmd.wr_item) begin
      if (burst_start) begin
        burst_ch_next = eff_ch;
        ch_use        = eff_ch;
        wfr_use       = '0;
        wch_use       = '0;
        wfr_next      = '0;
        wch_next      = '0;
        rem_next      = '0;
        bacc_next     = 1'b0;
        if (burst_frames == 11'd0) begin
          acc = 1'b0;
        end else if (32'(burst_frames) > 32'(free_frames)) begin
          if (ovf != '1) begin
            ovf_next = ovf + 32'd1;
          end
          rem_next = burst_len;
        end else begin
          bacc_next = 1'b1;
          rem_next  = burst_len;
          wr_en     = 1'b1;
          acc       = 1'b1;
        end
      end else if (rem != '0) begin
        rem_next = rem - RW'(1);
        acc      = bacc;
        wr_en    = bacc;
      end
      if (wr_en) begin
        if (32'(wch_use) + 32'd1 == 32'(ch_use)) begin
          wch_next = '0;
          wfr_next = wfr_use + PW'(1);
        end else begin
          wch_next = wch_use + CW'(1);
          wfr_next = wfr_use;
        end
      end
      // Commit the burst once its final sample is in.
      if (acc && rem_next == '0) begin
        wp_next   = PW'(wp + wfr_next);
        bacc_next = 1'b0;
        wfr_next  = '0;
        wch_next  = '0;
      end
      if (rem_next == '0) begin
        bacc_next = 1'b0;
      end
    end
  end

  always_comb begin
    rp_next = rp;
    if (cmd.rd_start) begin
      rp_next = PW'(32'(rp) + rd_cnt);
    end
  end

  assign pend_after = PW'(wp_next - rp_next);
  assign pend_wide  = 32'(pend_after);

  assign waddr = AW'(32'(PW'(wp + wfr_use) & PW'(CAPACITY_FRAMES - 1)) * MAX_CHANNELS
                     + 32'(wch_use));
  assign raddr = AW'(32'(rd_frame & PW'(CAPACITY_FRAMES - 1)) * MAX_CHANNELS
                     + 32'(rd_ch));

  // Sample store; contents undefined until written.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[waddr] <= sample;
    end
    if (cmd.mem_rd) begin
      mem_q <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      num_ch   <= 4'd1;
      wp       <= '0;
      rp       <= '0;
      bacc     <= 1'b0;
      rem      <= '0;
      wfr      <= '0;
      wch      <= '0;
      burst_ch <= NCW'(1);
      ovf      <= '0;
      rd_frame <= '0;
      rd_ch    <= '0;
      rd_fdone <= '0;
      rd_n     <= '0;
      rd_nch   <= NCW'(1);
    end else begin
      if (cfg_write) begin
        num_ch <= cfg_data;
      end
      wp       <= wp_next;
      rp       <= rp_next;
      bacc     <= bacc_next;
      rem      <= rem_next;
      wfr      <= wfr_next;
      wch      <= wch_next;
      burst_ch <= burst_ch_next;
      ovf      <= ovf_next;
      if (cmd.rd_start) begin
        rd_frame <= rp;
        rd_ch    <= '0;
        rd_fdone <= '0;
        rd_n     <= RFW'(rd_cnt);
        rd_nch   <= eff_ch;
      end else if (cmd.load_sample) begin
        if (32'(rd_ch) + 32'd1 == 32'(rd_nch)) begin
          rd_ch    <= '0;
          rd_frame <= rd_frame + PW'(1);
          rd_fdone <= rd_fdone + RFW'(1);
        end else begin
          rd_ch <= rd_ch + CW'(1);
        end
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.wr_item || cmd.rd_empty || cmd.stat_item || cmd.load_sample) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_item || cmd.rd_empty || cmd.stat_item || cmd.load_sample) begin
      frames_pending  <= pend_wide[10:0];
      overflow_count  <= ovf_next;
      sample_res      <= cmd.load_sample ? mem_q : 32'd0;
      accepted        <= cmd.wr_item && acc;
      frames_returned <= cmd.load_sample ? 4'(rd_n) : 4'd0;
      last            <= cmd.load_sample ? stat.rd_last : 1'b1;
      if (cmd.wr_item) begin
        kind <= KIND_WRITE_ACK;
      end else if (cmd.load_sample) begin
        kind <= KIND_READ_SAMPLE;
      end else if (cmd.rd_empty) begin
        kind <= KIND_READ_EMPTY;
      end else begin
        kind <= KIND_STATUS;
      end
    end
  end

endmodule

[hw/rtl/multichannel_frame_ring_fifo.sv]
// ----------------------------------------------------------------------------
// multichannel_frame_ring_fifo
// Ring FIFO of whole multichannel frames with burst drop and status query.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake              Payload
//  --------  ---------------------  ----------------------------------------
//  request   in_valid / in_ready    func, sample, burst_start, burst_frames,
//                                   max_frames
//  result    out_valid / out_ready  kind, sample_res, accepted,
//                                   frames_returned, frames_pending,
//                                   overflow_count, last
//  config    cfg_write              cfg_data (channel count)
//
//  Write, status and empty-read beats take one cycle each and stream back to
//  back while the result side keeps up. A read of n frames of c channels holds
//  the request side through the request beat, then a store read and an output
//  load per sample; a result stall holds back the output load until out_ready.
//  Reset clears pointers, burst state and the overflow counter at once and
//  holds in_ready low; the sample store is not cleared.
//
`include "multichannel_frame_ring_fifo_macros.svh"

module multichannel_frame_ring_fifo #(
  parameter int CAPACITY_FRAMES = 1024,
  parameter int MAX_CHANNELS    = 8,
  parameter int MAX_READ_FRAMES = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [3:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  func,
  input  logic [31:0] sample,
  input  logic        burst_start,
  input  logic [10:0] burst_frames,
  input  logic [3:0]  max_frames,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  kind,
  output logic [31:0] sample_res,
  output logic        accepted,
  output logic [3:0]  frames_returned,
  output logic [10:0] frames_pending,
  output logic [31:0] overflow_count,
  output logic        last
);
  import mfrf_pkg::*;

  mfrf_cmd_t  cmd;
  mfrf_stat_t stat;
  logic       item_beat;
  logic [4:0] actions;

  // Sequencer: decodes request beats, walks reads sample by sample.
  mfrf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .func     (func),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Store, pointers, burst tracking and the output register.
  mfrf_datapath #(
    .CAPACITY_FRAMES (CAPACITY_FRAMES),
    .MAX_CHANNELS    (MAX_CHANNELS),
    .MAX_READ_FRAMES (MAX_READ_FRAMES)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cfg_write       (cfg_write),
    .cfg_data        (cfg_data),
    .sample          (sample),
    .burst_start     (burst_start),
    .burst_frames    (burst_frames),
    .max_frames      (max_frames),
    .cmd             (cmd),
    .stat            (stat),
    .out_ready       (out_ready),
    .out_valid       (out_valid),
    .kind            (kind),
    .sample_res      (sample_res),
    .accepted        (accepted),
    .frames_returned (frames_returned),
    .frames_pending  (frames_pending),
    .overflow_count  (overflow_count),
    .last            (last)
  );

  // Request beats that load their single result at once.
  assign item_beat = cmd.wr_item || cmd.rd_empty || cmd.stat_item;
  assign actions   = {cmd.wr_item, cmd.rd_start, cmd.rd_empty, cmd.stat_item,
                      cmd.load_sample};

  // Take a request only when its result has a free output slot.
  `MFRF_ASSERT_SAME(a_ready_needs_slot, in_ready, (!out_valid || out_ready), "no free output slot")
  // Every write, status or empty-read beat leaves a result beat in the output register.
  `MFRF_ASSERT_NEXT(a_accept_gives_beat, item_beat, out_valid, "request gave no result beat")
  // Hold off requests while a fetched sample is on its way out.
  `MFRF_ASSERT_NEXT(a_busy_after_fetch, cmd.mem_rd, !in_ready, "request taken while streaming")
  // At most one datapath action per cycle.
  `MFRF_ASSERT_SAME(a_one_action, 1'b1, $onehot0(actions), "conflicting datapath commands")

endmodule
